// File: hw/rtl/gsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsi_pkg
// Shared types and codes for the gradient stop interpolation block.
// ----------------------------------------------------------------------------
package gsi_pkg;

    localparam int POS_W  = 16;
    localparam int COMP_W = 16;

    // Request kinds.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/gradient_stop_interpolation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_stop_interpolation
// Sorted table of colour stops in one RAM; inserts stops and answers
// colour queries by linear interpolation between neighbouring stops.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tuser: opcode; tdata: position, comp_a..comp_d
//  m_axis   | out       | tdata: out_a..out_d; tuser: status
//
// Each request is handled alone, from one accept to the next. A scan reads one
// stop per cycle from the stop RAM. An insert at a new position then shifts the tail
// up one stop at a time, reading it (S_SHIFT_RD) and writing it one place higher
// (S_SHIFT_WR), and then writes the new stop. An interpolating query then divides
// bit by bit (S_DIV) and does a multiply (S_MUL) and an add (S_ADD) per channel.
// Reset (synchronous, active low) empties the table; the RAM is not cleared.
// A finished result waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module gradient_stop_interpolation
    import gsi_pkg::*;
#(
    parameter int MAX_STOPS = 16,
    parameter int CHANNELS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // position, comp_a, comp_b, comp_c, comp_d
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_a, out_b, out_c, out_d
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int ENTRY_W = POS_W + COMP_W * CHANNELS;
    localparam int IDX_W   = $clog2(MAX_STOPS);
    localparam int CNT_W   = $clog2(MAX_STOPS + 1);
    localparam int BIT_W   = $clog2(FRAC_BITS + 1);
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W  = COMP_W + FRAC_BITS;
    localparam int RES_W   = COMP_W * CHANNELS;

    t_state r_state, n_state;

    logic               r_op;
    logic [POS_W-1:0]   r_pos, r_span;
    logic [RES_W-1:0]   r_comps;
    logic [CNT_W-1:0]   r_idx, n_idx, r_k, n_k, r_count, n_count;
    logic [ENTRY_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [POS_W-1:0]   r_rem, n_rem, n_span;
    logic [FRAC_BITS-1:0] r_quo, n_quo;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic               r_neg, n_neg;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [RES_W-1:0]   r_res, n_res;
    logic [1:0]         r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic [63:0]        r_out_data, n_out_data;
    logic [1:0]         r_out_status, n_out_status;

    // RAM controls.
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

    // Helper views.
    logic               accept, out_free, at_end, found, hit;
    logic [POS_W-1:0]   rd_pos, lo_pos;
    logic [ENTRY_W-1:0] new_entry;
    logic [POS_W:0]     rem_sh;
    logic               quo_bit;
    logic [COMP_W-1:0]  c0, c1, dlt;

    gsi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // Scan decisions on the stop just read.
    assign rd_pos    = ram_rd_data[POS_W-1:0];
    assign lo_pos    = r_lo[POS_W-1:0];
    assign at_end    = (r_idx == r_count);
    assign found     = at_end || !(rd_pos < r_pos);
    assign hit       = !at_end && (rd_pos == r_pos);
    assign new_entry = {r_comps, r_pos};

    // Division step and per-channel operands.
    assign rem_sh  = {r_rem, 1'b0};
    assign quo_bit = (rem_sh >= {1'b0, r_span});
    assign c0      = r_lo[POS_W + COMP_W * r_ch +: COMP_W];
    assign c1      = r_hi[POS_W + COMP_W * r_ch +: COMP_W];
    assign dlt     = r_prod[FRAC_BITS +: COMP_W];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == OP_QUERY && r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    if (r_op == OP_INSERT) begin
                        if (hit || r_count == CNT_W'(MAX_STOPS)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SHIFT_RD;
                        end
                    end else if (at_end || r_idx == '0 || hit) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SHIFT_RD: n_state = (r_idx > r_k) ? S_SHIFT_WR : S_DONE;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_DIV:      n_state = (r_bit == BIT_W'(1)) ? S_MUL : S_DIV;
            S_MUL:      n_state = S_ADD;
            S_ADD:      n_state = (r_ch == CH_W'(CHANNELS - 1)) ? S_DONE : S_MUL;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM controls.
    always_comb begin
        n_idx        = r_idx;
        n_k          = r_k;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_rem        = r_rem;
        n_span       = r_span;
        n_quo        = r_quo;
        n_bit        = r_bit;
        n_ch         = r_ch;
        n_neg        = r_neg;
        n_prod       = r_prod;
        n_res        = r_res;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_idx[IDX_W-1:0];
        ram_wr_data  = new_entry;
        ram_rd_addr  = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_idx       = '0;
                n_res       = '0;
                n_status    = ST_OK;
                ram_rd_addr = '0;
                if (accept && s_axis_tuser == OP_QUERY && r_count == '0) begin
                    n_status = ST_EMPTY;
                end
            end
            S_SCAN: begin
                if (!found) begin
                    // Still below the requested position: keep this stop as the left one.
                    n_lo        = ram_rd_data;
                    n_idx       = r_idx + 1'b1;
                    ram_rd_addr = IDX_W'(r_idx + 1'b1);
                end else if (r_op == OP_INSERT) begin
                    if (hit) begin
                        ram_wr_en = 1'b1;
                    end else if (r_count == CNT_W'(MAX_STOPS)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_k   = r_idx;
                        n_idx = r_count;
                    end
                end else if (at_end) begin
                    n_res = r_lo[ENTRY_W-1:POS_W];
                end else if (r_idx == '0 || hit) begin
                    n_res = ram_rd_data[ENTRY_W-1:POS_W];
                end else begin
                    n_hi   = ram_rd_data;
                    n_rem  = r_pos - lo_pos;
                    n_span = rd_pos - lo_pos;
                    n_bit  = BIT_W'(FRAC_BITS);
                    n_ch   = '0;
                end
            end
            S_SHIFT_RD: begin
                // Move one stop up by one place, from the top down; at the gap, write the new stop.
                ram_rd_addr = IDX_W'(r_idx - 1'b1);
                if (!(r_idx > r_k)) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_k[IDX_W-1:0];
                    n_count     = r_count + 1'b1;
                end
            end
            S_SHIFT_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
                n_idx       = r_idx - 1'b1;
            end
            S_DIV: begin
                // One quotient bit per cycle.
                n_rem = quo_bit ? POS_W'(rem_sh - {1'b0, r_span}) : rem_sh[POS_W-1:0];
                n_quo = {r_quo[FRAC_BITS-2:0], quo_bit};
                n_bit = r_bit - 1'b1;
            end
            S_MUL: begin
                n_neg  = (c1 < c0);
                n_prod = PROD_W'((c1 < c0) ? (c0 - c1) : (c1 - c0)) * PROD_W'(r_quo);
            end
            S_ADD: begin
                n_res[COMP_W * r_ch +: COMP_W] = r_neg ? (c0 - dlt) : (c0 + dlt);
                n_ch = r_ch + 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = 64'(r_res);
                    n_out_status = r_status;
                end
            end
            default: begin
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        if (accept) begin
            r_op    <= s_axis_tuser;
            r_pos   <= s_axis_tdata[POS_W-1:0];
            r_comps <= s_axis_tdata[POS_W +: RES_W];
        end
        r_idx        <= n_idx;
        r_k          <= n_k;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_rem        <= n_rem;
        r_span       <= n_span;
        r_quo        <= n_quo;
        r_bit        <= n_bit;
        r_ch         <= n_ch;
        r_neg        <= n_neg;
        r_prod       <= n_prod;
        r_res        <= n_res;
        r_status     <= n_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

endmodule

// File: hw/rtl/gsi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gsi_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
